FILE: rtl/cfz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfz_pkg
// Shared types and constants of the cursor follow zoom viewport block.
// ----------------------------------------------------------------------------
package cfz_pkg;

  // fixed field widths
  localparam int unsigned ZOOM_W     = 16;
  localparam int unsigned SCREEN_W   = 13;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_CURSOR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MAGNIFY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNMAGNIFY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ENLARGE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHRINK    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_ZOOM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_STEP_UP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_STEP_DOWN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd4;

  // register reset values
  localparam logic [ZOOM_W-1:0]   RST_PRESET_ZOOM    = 16'd512;
  localparam logic [ZOOM_W-1:0]   RST_ZOOM_STEP_UP   = 16'd64;
  localparam logic [ZOOM_W-1:0]   RST_ZOOM_STEP_DOWN = 16'd64;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH   = 13'd1920;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT  = 13'd1080;

  // zoom constants, Q8.8
  localparam logic [ZOOM_W-1:0] ONE_Q88  = 16'd256;
  localparam logic [ZOOM_W-1:0] ZOOM_MAX = 16'hFFFF;

  // edge dead zone 0.1 as a 16-bit fraction
  localparam logic [12:0] DEAD_ZONE_Q16 = 13'd6554;

  // per-lane step strobes from the sequencer
  typedef struct packed {
    logic div_start;
    logic mul_en;
    logic prod_en;
    logic sub_en;
  } lane_ctl_t;

endpackage : cfz_pkg
`default_nettype wire

FILE: rtl/cfz_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfz_if
// Valid/ready channels of the viewport block: command, result and register
// write.
// ----------------------------------------------------------------------------

// command channel
interface cfz_in_if #(
  parameter int unsigned COORD_BITS = 13
);
  import cfz_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;

  modport source (output valid, output mode, output cursor_x, output cursor_y,
                  input ready);
  modport sink   (input valid, input mode, input cursor_x, input cursor_y,
                  output ready);
endinterface : cfz_in_if

// result channel
interface cfz_out_if #(
  parameter int unsigned COORD_BITS = 13
);
  import cfz_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ZOOM_W-1:0]     zoom_now;
  logic                  is_zoomed;
  logic [COORD_BITS-1:0] offset_x;
  logic [COORD_BITS-1:0] offset_y;
  logic [COORD_BITS-1:0] view_width;
  logic [COORD_BITS-1:0] view_height;
  logic                  clipped;

  modport source (output valid, output zoom_now, output is_zoomed,
                  output offset_x, output offset_y, output view_width,
                  output view_height, output clipped, input ready);
  modport sink   (input valid, input zoom_now, input is_zoomed,
                  input offset_x, input offset_y, input view_width,
                  input view_height, input clipped, output ready);
endinterface : cfz_out_if

// register write channel
interface cfz_cfg_if;
  import cfz_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : cfz_cfg_if
`default_nettype wire

FILE: rtl/cfz_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfz_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfz_div #(
  parameter int unsigned NUM_W = 25,
  parameter int unsigned DEN_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [NUM_W-1:0] quo_o,
  output logic                  busy_o
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    fits    = (shifted >= {1'b0, den_q});
    rem_d   = fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
    quo_d   = {quo_q[NUM_W-2:0], fits};
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o  = quo_q;
  assign busy_o = busy_q;

endmodule : cfz_div
`default_nettype wire

FILE: rtl/cfz_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfz_lane
// One axis lane: source size by division, and the cursor to viewport offset
// mapping through a short multiply pipeline.
// ----------------------------------------------------------------------------
module cfz_lane #(
  parameter int unsigned COORD_BITS      = 13,
  parameter int unsigned RECIP_FRAC_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cfz_pkg::lane_ctl_t             ctl_i,
  input  wire logic [cfz_pkg::ZOOM_W-1:0]     zoom_i,
  input  wire logic [cfz_pkg::SCREEN_W-1:0]   size_i,
  input  wire logic [COORD_BITS-1:0]          coord_i,
  input  wire logic [RECIP_FRAC_BITS-1:0]     recip_i,
  output logic      [COORD_BITS-1:0]          view_o,
  output logic      [COORD_BITS-1:0]          offset_o,
  output logic                                busy_o
);
  import cfz_pkg::*;

  localparam int unsigned R      = RECIP_FRAC_BITS;
  localparam int unsigned VQ_W   = SCREEN_W + 8;
  localparam int unsigned M_W    = R + 20;
  localparam int unsigned MUL_W  = R + 2;
  localparam int unsigned POS_W  = COORD_BITS + MUL_W;
  localparam int unsigned MS_W   = SCREEN_W + MUL_W;
  localparam int unsigned SUB_W  = MS_W + 13;
  localparam int unsigned LIMP_W = SCREEN_W + R + 1;
  localparam int unsigned CMP_W  = (POS_W > MS_W) ? POS_W : MS_W;
  localparam int unsigned OFF_W  = CMP_W - R;
  localparam logic [VQ_W-1:0] VIEW_MAX = VQ_W'((1 << COORD_BITS) - 1);

  // source size divider: (size * 256) / zoom
  logic [VQ_W-1:0] view_quo;

  cfz_div #(
    .NUM_W (VQ_W),
    .DEN_W (ZOOM_W)
  ) u_view_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_start),
    .num_i   ({size_i, 8'd0}),
    .den_i   (zoom_i),
    .quo_o   (view_quo),
    .busy_o  (busy_o)
  );

  // saturate source size, zero factor saturates unless the screen is empty
  always_comb begin
    if (zoom_i == '0) begin
      view_o = (size_i == '0) ? '0 : COORD_BITS'(VIEW_MAX);
    end else if (view_quo > VIEW_MAX) begin
      view_o = COORD_BITS'(VIEW_MAX);
    end else begin
      view_o = COORD_BITS'(view_quo);
    end
  end

  // gain: (1 - 1/f) * 65536 / 52428, done as 5m/4 * 65536/65535
  logic [R:0]       omr_d;
  logic [M_W-1:0]   m5, hi_part, lo_sum, mul_sum;
  logic             carry_fix;
  logic [MUL_W-1:0] mul_d;

  always_comb begin
    omr_d     = {1'b1, {R{1'b0}}} - {1'b0, recip_i};
    m5        = (M_W'(omr_d) << 2) + M_W'(omr_d);
    hi_part   = m5 >> 16;
    lo_sum    = M_W'(m5[15:0]) + hi_part;
    carry_fix = (lo_sum >= M_W'(16'hFFFF));
    mul_sum   = m5 + hi_part + M_W'(carry_fix);
    mul_d     = MUL_W'(mul_sum >> 2);
  end

  // multiply pipeline
  logic [MUL_W-1:0]    mul_q;
  logic [R:0]          omr_q;
  logic [POS_W-1:0]    pos_q;
  logic [MS_W-1:0]     ms_q, sub_q;
  logic [SCREEN_W-1:0] lim_q;
  logic [LIMP_W-1:0]   lim_prod;
  logic [SUB_W-1:0]    sub_prod;

  assign lim_prod = LIMP_W'(size_i) * LIMP_W'(omr_q);
  assign sub_prod = SUB_W'(ms_q) * SUB_W'(DEAD_ZONE_Q16);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      mul_q <= mul_d;
      omr_q <= omr_d;
    end
    if (ctl_i.prod_en) begin
      pos_q <= POS_W'(coord_i) * POS_W'(mul_q);
      ms_q  <= MS_W'(size_i) * MS_W'(mul_q);
      lim_q <= lim_prod[R +: SCREEN_W];
    end
    if (ctl_i.sub_en) begin
      sub_q <= MS_W'(sub_prod >> 16);
    end
  end

  // subtract the dead zone, drop the fraction, clamp to the right edge
  logic [CMP_W-1:0] pos_w, sub_w, diff;
  logic [OFF_W-1:0] off_raw, off_lim;

  always_comb begin
    pos_w   = CMP_W'(pos_q);
    sub_w   = CMP_W'(sub_q);
    diff    = (pos_w > sub_w) ? (pos_w - sub_w) : '0;
    off_raw = OFF_W'(diff >> R);
    off_lim = (off_raw > OFF_W'(lim_q)) ? OFF_W'(lim_q) : off_raw;
    offset_o = COORD_BITS'(off_lim);
  end

endmodule : cfz_lane
`default_nettype wire

FILE: rtl/cursor_follow_zoom_viewport.sv
`timescale 1ns / 1ps
`default_nettype none
// The result follows the command beat once the slower of the bit-serial reciprocal
//   divider (RECIP_FRAC_BITS + 9 steps) and the 21-step source size divider is
//   done.
// One command at a time; the next command is taken once the result is loaded,
//   also while that result still waits in the output register.
// Reset: zoom 1.0, not magnified, registers at their defaults, no result pending.
// ----------------------------------------------------------------------------
// cursor_follow_zoom_viewport
// Zoom state, command decode and sequencer; two axis lanes compute source
// size and viewport offset, merged here into the result register.
// ----------------------------------------------------------------------------
module cursor_follow_zoom_viewport #(
  parameter int unsigned COORD_BITS      = 13,
  parameter int unsigned RECIP_FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cfz_cfg_if.sink   cfg_i,
  cfz_in_if.sink    in_i,
  cfz_out_if.source out_o
);
  import cfz_pkg::*;

  localparam int unsigned R       = RECIP_FRAC_BITS;
  localparam int unsigned RQ_W    = R + 9;
  localparam logic [RQ_W-1:0] RECIP_NUM = RQ_W'(1) << (R + 8);
  localparam int unsigned FULL_W  = SCREEN_W + 4;
  localparam logic [FULL_W-1:0] FULL_MAX = FULL_W'((1 << COORD_BITS) - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_PROD  = 3'd4;
  localparam logic [2:0] ST_SUB   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // register file
  logic [ZOOM_W-1:0]   preset_zoom_q, step_up_q, step_down_q;
  logic [SCREEN_W-1:0] screen_w_q, screen_h_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_zoom_q <= RST_PRESET_ZOOM;
      step_up_q     <= RST_ZOOM_STEP_UP;
      step_down_q   <= RST_ZOOM_STEP_DOWN;
      screen_w_q    <= RST_SCREEN_WIDTH;
      screen_h_q    <= RST_SCREEN_HEIGHT;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PRESET_ZOOM:    preset_zoom_q <= cfg_i.data;
        REG_ZOOM_STEP_UP:   step_up_q     <= cfg_i.data;
        REG_ZOOM_STEP_DOWN: step_down_q   <= cfg_i.data;
        REG_SCREEN_WIDTH:   screen_w_q    <= cfg_i.data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT:  screen_h_q    <= cfg_i.data[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [2:0] state_q, state_d;
  logic       in_fire, out_load, out_valid_q;
  logic       recip_busy, lane_x_busy, lane_y_busy;
  lane_ctl_t  ctl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (!recip_busy && !lane_x_busy && !lane_y_busy) state_d = ST_MUL;
      ST_MUL:   state_d = ST_PROD;
      ST_PROD:  state_d = ST_SUB;
      ST_SUB:   state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.div_start = (state_q == ST_START);
    ctl.mul_en    = (state_q == ST_MUL);
    ctl.prod_en   = (state_q == ST_PROD);
    ctl.sub_en    = (state_q == ST_SUB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // zoom state update on a command beat
  logic [ZOOM_W-1:0]     zoom_q;
  logic                  zoomed_q, track_q, clip_q;
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic [ZOOM_W:0]       zoom_sum;

  assign zoom_sum = {1'b0, zoom_q} + {1'b0, step_up_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q   <= ONE_Q88;
      zoomed_q <= 1'b0;
    end else if (in_fire) begin
      case (in_i.mode)
        MODE_MAGNIFY: begin
          zoomed_q <= 1'b1;
          zoom_q   <= preset_zoom_q;
        end
        MODE_UNMAGNIFY: begin
          zoomed_q <= 1'b0;
          zoom_q   <= ONE_Q88;
        end
        MODE_ENLARGE: begin
          if (zoomed_q) begin
            zoom_q <= zoom_sum[ZOOM_W] ? ZOOM_MAX : zoom_sum[ZOOM_W-1:0];
          end
        end
        MODE_SHRINK: begin
          if (zoomed_q && (step_down_q < zoom_q)) begin
            zoom_q <= zoom_q - step_down_q;
          end
        end
        default: ;
      endcase
    end
  end

  // per-command flags and cursor
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      track_q <= !((in_i.mode == MODE_MAGNIFY) || (in_i.mode == MODE_UNMAGNIFY) ||
                   (in_i.mode == MODE_ENLARGE) || (in_i.mode == MODE_SHRINK));
      clip_q  <= (in_i.mode == MODE_ENLARGE) && zoomed_q && zoom_sum[ZOOM_W];
      cur_x_q <= in_i.cursor_x;
      cur_y_q <= in_i.cursor_y;
    end
  end

  // shared reciprocal 1/f
  logic [RQ_W-1:0] recip_quo;

  cfz_div #(
    .NUM_W (RQ_W),
    .DEN_W (ZOOM_W)
  ) u_recip_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .num_i   (RECIP_NUM),
    .den_i   (zoom_q),
    .quo_o   (recip_quo),
    .busy_o  (recip_busy)
  );

  // axis lanes
  logic [COORD_BITS-1:0] view_x, view_y, off_x, off_y;

  cfz_lane #(
    .COORD_BITS      (COORD_BITS),
    .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
  ) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .zoom_i   (zoom_q),
    .size_i   (screen_w_q),
    .coord_i  (cur_x_q),
    .recip_i  (recip_quo[R-1:0]),
    .view_o   (view_x),
    .offset_o (off_x),
    .busy_o   (lane_x_busy)
  );

  cfz_lane #(
    .COORD_BITS      (COORD_BITS),
    .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
  ) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .zoom_i   (zoom_q),
    .size_i   (screen_h_q),
    .coord_i  (cur_y_q),
    .recip_i  (recip_quo[R-1:0]),
    .view_o   (view_y),
    .offset_o (off_y),
    .busy_o   (lane_y_busy)
  );

  // full screen size while not magnified, saturated to the output width
  logic [COORD_BITS-1:0] full_w, full_h;

  assign full_w = ({4'd0, screen_w_q} > FULL_MAX) ? COORD_BITS'(FULL_MAX)
                                                  : COORD_BITS'(screen_w_q);
  assign full_h = ({4'd0, screen_h_q} > FULL_MAX) ? COORD_BITS'(FULL_MAX)
                                                  : COORD_BITS'(screen_h_q);

  // merge lanes into the result register
  logic                  show_off;
  logic [ZOOM_W-1:0]     res_zoom_q;
  logic                  res_zoomed_q, res_clip_q;
  logic [COORD_BITS-1:0] res_off_x_q, res_off_y_q, res_view_w_q, res_view_h_q;

  assign show_off = zoomed_q && track_q && (zoom_q > ONE_Q88);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_zoom_q   <= zoomed_q ? zoom_q : ONE_Q88;
      res_zoomed_q <= zoomed_q;
      res_off_x_q  <= show_off ? off_x : '0;
      res_off_y_q  <= show_off ? off_y : '0;
      res_view_w_q <= zoomed_q ? view_x : full_w;
      res_view_h_q <= zoomed_q ? view_y : full_h;
      res_clip_q   <= clip_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.zoom_now    = res_zoom_q;
  assign out_o.is_zoomed   = res_zoomed_q;
  assign out_o.offset_x    = res_off_x_q;
  assign out_o.offset_y    = res_off_y_q;
  assign out_o.view_width  = res_view_w_q;
  assign out_o.view_height = res_view_h_q;
  assign out_o.clipped     = res_clip_q;

endmodule : cursor_follow_zoom_viewport
`default_nettype wire

FILE: rtl/cfz_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfz_checker
// Port-level checks of the viewport block, bound to the top level.
// ----------------------------------------------------------------------------
module cfz_checker #(
  parameter int unsigned COORD_BITS = 13
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [cfz_pkg::ZOOM_W-1:0]      zoom_now,
  input wire logic                            is_zoomed,
  input wire logic [COORD_BITS-1:0]           offset_x,
  input wire logic [COORD_BITS-1:0]           offset_y,
  input wire logic [COORD_BITS-1:0]           view_width,
  input wire logic [COORD_BITS-1:0]           view_height,
  input wire logic                            clipped
);
  import cfz_pkg::*;

  // a stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(zoom_now) &&
      $stable(offset_x) && $stable(offset_y) && $stable(view_width) &&
      $stable(view_height) && $stable(is_zoomed) && $stable(clipped))
    else $error("result beat changed while stalled");

  // one command at a time: busy right after a command beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one in flight");

  // off state reports unit zoom and no offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !is_zoomed |-> zoom_now == ONE_Q88 && offset_x == '0 && offset_y == '0)
    else $error("offset or zoom reported while not magnified");

  // no panning at zoom 1.0 or below
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && zoom_now <= ONE_Q88 |-> offset_x == '0 && offset_y == '0)
    else $error("nonzero offset at zoom of one or less");

  // clipping only when magnified and saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && clipped |-> is_zoomed && zoom_now == ZOOM_MAX)
    else $error("clipped without saturated zoom");

endmodule : cfz_checker

bind cursor_follow_zoom_viewport cfz_checker #(
  .COORD_BITS (COORD_BITS)
) u_cfz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .zoom_now    (out_o.zoom_now),
  .is_zoomed   (out_o.is_zoomed),
  .offset_x    (out_o.offset_x),
  .offset_y    (out_o.offset_y),
  .view_width  (out_o.view_width),
  .view_height (out_o.view_height),
  .clipped     (out_o.clipped)
);
`default_nettype wire
